[src/i2cm_pkg.sv]
// shared types and codes for the i2c master bit engine
`default_nettype none

package i2cm_pkg;

   // bus command codes carried by the action field
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_ACK   = 3'd3,
      ACT_NACK  = 3'd4,
      ACT_WAIT  = 3'd5,
      ACT_SEND  = 3'd6,
      ACT_RECV  = 3'd7
   } action_type;

   // outcome of the last finished command
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BUS_BUSY   = 2'd1,
      ST_STUCK_HIGH = 2'd2,
      ST_NO_ACK     = 2'd3
   } status_type;

   localparam int unsigned TICK_W       = 16;
   localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd50;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // everything the engine keeps from one tick to the next
   typedef struct packed {
      action_type        kind;
      logic [2:0]        phase_index;
      logic [3:0]        bit_index;
      logic [7:0]        shift_byte;
      logic [TICK_W-1:0] tick_count;
      logic              scl_drive;
      logic              sda_drive;
      status_type        last_status;
      logic [7:0]        held_byte;
   } bus_state_type;

   // one result word
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      status_type status;
   } result_type;

   // line drives touched when a phase is entered
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] shift;
   } drive_type;

endpackage

`default_nettype wire

[src/i2cm_step.sv]
// next-state and result logic for one bus tick of the i2c master
`default_nettype none

module i2cm_step (
   input  wire i2cm_pkg::bus_state_type state_ff,
   input  wire logic [2:0]               action,
   input  wire logic [7:0]               send_data,
   input  wire logic                     sda_line,
   input  wire logic [15:0]              phase_ticks,
   output i2cm_pkg::bus_state_type       state_in,
   output i2cm_pkg::result_type          result
);

   // drives set on entry to a phase
   function automatic i2cm_pkg::drive_type enter_phase(i2cm_pkg::action_type kind,
                                                       logic [2:0] p,
                                                       i2cm_pkg::drive_type d);
      i2cm_pkg::drive_type r;
      r = d;
      unique case (kind)
         i2cm_pkg::ACT_START: begin
            if (p == 3'd0) begin
               r.sda = 1'b1;
               r.scl = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         i2cm_pkg::ACT_STOP: begin
            if (p == 3'd0) r.scl = 1'b0;
            else if (p == 3'd1) r.sda = 1'b0;
            else if (p == 3'd2) r.scl = 1'b1;
            else r.sda = 1'b1;
         end
         i2cm_pkg::ACT_ACK, i2cm_pkg::ACT_NACK: begin
            if (p == 3'd0) r.scl = 1'b0;
            else if (p == 3'd1) r.sda = (kind == i2cm_pkg::ACT_NACK);
            else if (p == 3'd2) r.scl = 1'b1;
            else r.scl = 1'b0;
         end
         i2cm_pkg::ACT_WAIT: begin
            if (p == 3'd0) r.scl = 1'b0;
            else if (p == 3'd1) r.sda = 1'b1;
            else r.scl = 1'b1;
         end
         i2cm_pkg::ACT_SEND: begin
            if (p == 3'd0) begin
               r.scl = 1'b0;
            end else if (p == 3'd1) begin
               r.sda   = d.shift[7];
               r.shift = {d.shift[6:0], 1'b0};
            end else begin
               r.scl = 1'b1;
            end
         end
         i2cm_pkg::ACT_RECV: begin
            r.scl = (p != 3'd0);
         end
         i2cm_pkg::ACT_NONE: begin
            r = d;
         end
      endcase
      return r;
   endfunction

   i2cm_pkg::bus_state_type nxt;
   i2cm_pkg::action_type    act;
   i2cm_pkg::drive_type     drv;
   logic [15:0]             tick_inc;
   logic [15:0]             limit;
   logic [3:0]              bit_inc;
   logic [2:0]              phase_inc;
   logic [7:0]              recv_byte;
   logic                    finish;
   logic                    busy;
   logic                    done;

   always_comb begin
      nxt       = state_ff;
      act       = i2cm_pkg::action_type'(action);
      drv       = '0;
      busy      = 1'b0;
      done      = 1'b0;
      finish    = 1'b0;
      tick_inc  = state_ff.tick_count + 16'd1;
      limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
      bit_inc   = state_ff.bit_index + 4'd1;
      phase_inc = state_ff.phase_index + 3'd1;
      recv_byte = {state_ff.shift_byte[6:0], sda_line};

      if (state_ff.kind == i2cm_pkg::ACT_NONE) begin
         // idle: an action word launches a command in phase 0
         if (act != i2cm_pkg::ACT_NONE) begin
            nxt.kind        = act;
            nxt.phase_index = 3'd0;
            nxt.bit_index   = 4'd0;
            nxt.tick_count  = 16'd0;
            if (act == i2cm_pkg::ACT_SEND) begin
               nxt.shift_byte = send_data;
            end else if (act == i2cm_pkg::ACT_RECV) begin
               nxt.shift_byte = 8'd0;
               nxt.sda_drive  = 1'b1;
            end
            drv = enter_phase(act, 3'd0, {nxt.scl_drive, nxt.sda_drive, nxt.shift_byte});
            nxt.scl_drive  = drv.scl;
            nxt.sda_drive  = drv.sda;
            nxt.shift_byte = drv.shift;
            busy = 1'b1;
         end
      end else if (tick_inc >= limit) begin
         // last tick of a phase: sample, then advance or finish
         nxt.tick_count = 16'd0;
         unique case (state_ff.kind)
            i2cm_pkg::ACT_START: begin
               if (state_ff.phase_index == 3'd0 && !sda_line) begin
                  nxt.last_status = i2cm_pkg::ST_BUS_BUSY;
                  finish = 1'b1;
               end else if (state_ff.phase_index == 3'd1 && sda_line) begin
                  nxt.last_status = i2cm_pkg::ST_STUCK_HIGH;
                  finish = 1'b1;
               end else if (state_ff.phase_index >= 3'd2) begin
                  nxt.last_status = i2cm_pkg::ST_OK;
                  finish = 1'b1;
               end else begin
                  nxt.phase_index = phase_inc;
               end
            end
            i2cm_pkg::ACT_STOP, i2cm_pkg::ACT_ACK, i2cm_pkg::ACT_NACK: begin
               if (state_ff.phase_index >= 3'd3) begin
                  nxt.last_status = i2cm_pkg::ST_OK;
                  finish = 1'b1;
               end else begin
                  nxt.phase_index = phase_inc;
               end
            end
            i2cm_pkg::ACT_WAIT: begin
               if (state_ff.phase_index >= 3'd2) begin
                  nxt.last_status = sda_line ? i2cm_pkg::ST_NO_ACK : i2cm_pkg::ST_OK;
                  nxt.scl_drive   = 1'b0;
                  finish = 1'b1;
               end else begin
                  nxt.phase_index = phase_inc;
               end
            end
            i2cm_pkg::ACT_SEND: begin
               if (state_ff.phase_index >= 3'd2) begin
                  nxt.bit_index = bit_inc;
                  if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                     nxt.scl_drive   = 1'b0;
                     nxt.last_status = i2cm_pkg::ST_OK;
                     finish = 1'b1;
                  end else begin
                     nxt.phase_index = 3'd0;
                  end
               end else begin
                  nxt.phase_index = phase_inc;
               end
            end
            i2cm_pkg::ACT_RECV: begin
               if (state_ff.phase_index >= 3'd1) begin
                  nxt.shift_byte = recv_byte;
                  nxt.bit_index  = bit_inc;
                  if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                     nxt.held_byte   = recv_byte;
                     nxt.scl_drive   = 1'b0;
                     nxt.last_status = i2cm_pkg::ST_OK;
                     finish = 1'b1;
                  end else begin
                     nxt.phase_index = 3'd0;
                  end
               end else begin
                  nxt.phase_index = phase_inc;
               end
            end
            i2cm_pkg::ACT_NONE: begin
               finish = 1'b1;
            end
         endcase

         if (finish) begin
            nxt.kind        = i2cm_pkg::ACT_NONE;
            nxt.phase_index = 3'd0;
            nxt.bit_index   = 4'd0;
            done = 1'b1;
         end else begin
            drv = enter_phase(nxt.kind, nxt.phase_index,
                              {nxt.scl_drive, nxt.sda_drive, nxt.shift_byte});
            nxt.scl_drive  = drv.scl;
            nxt.sda_drive  = drv.sda;
            nxt.shift_byte = drv.shift;
            busy = 1'b1;
         end
      end else begin
         // mid-phase: just count
         nxt.tick_count = tick_inc;
         busy = 1'b1;
      end
   end

   // outputs reflect the state after this tick
   assign state_in         = nxt;
   assign result.scl_level = nxt.scl_drive;
   assign result.sda_level = nxt.sda_drive;
   assign result.busy_res  = busy;
   assign result.done_res  = done;
   assign result.read_data = nxt.held_byte;
   assign result.status    = nxt.last_status;

endmodule

`default_nettype wire

[src/i2c_master_bit_engine.sv]
// top level of the i2c master bit engine: input register, tick logic, result register
// a word goes from the input register through the tick logic into the result register
// throughput: one word per cycle while rsp_ready holds; bus state steps once per word
// reset: synchronous, active high; lines released, engine idle, phase_ticks back to 50
`default_nettype none

module i2c_master_bit_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_send_data,
   input  wire logic        req_sda_line,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic                    in_valid_ff;
   logic [2:0]              in_action_ff;
   logic [7:0]              in_data_ff;
   logic                    in_sda_ff;
   logic                    out_valid_ff;
   i2cm_pkg::result_type    out_ff;
   i2cm_pkg::bus_state_type state_ff;
   i2cm_pkg::bus_state_type state_in;
   i2cm_pkg::result_type    result_in;
   logic [15:0]             phase_ticks_ff;
   logic                    advance;

   // a word moves to the result register when that register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_data_ff   <= req_send_data;
         in_sda_ff    <= req_sda_line;
      end
   end

   // tick logic
   i2cm_step u_step (
      .state_ff    (state_ff),
      .action      (in_action_ff),
      .send_data   (in_data_ff),
      .sda_line    (in_sda_ff),
      .phase_ticks (phase_ticks_ff),
      .state_in    (state_in),
      .result      (result_in)
   );

   // bus state steps once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.kind        <= i2cm_pkg::ACT_NONE;
         state_ff.phase_index <= 3'd0;
         state_ff.bit_index   <= 4'd0;
         state_ff.shift_byte  <= 8'd0;
         state_ff.tick_count  <= 16'd0;
         state_ff.scl_drive   <= 1'b1;
         state_ff.sda_drive   <= 1'b1;
         state_ff.last_status <= i2cm_pkg::ST_OK;
         state_ff.held_byte   <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = out_ff.scl_level;
   assign rsp_sda_level = out_ff.sda_level;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_status    = out_ff.status;

`ifndef SYNTH
   // a finishing tick never also reports busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_busy_res && rsp_done_res))
      else $error("result word both busy and done");

   // idle engine holds cleared phase and bit counters
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.kind == i2cm_pkg::ACT_NONE) |->
         (state_ff.phase_index == 3'd0 && state_ff.bit_index == 4'd0))
      else $error("idle engine with stale counters");

   // bit counter never rests at a full byte
   assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_index < i2cm_pkg::BITS_PER_BYTE)
      else $error("bit counter out of range");

   // a stalled result register blocks the state update
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(state_ff))
      else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire
